// ----- hdl/bus_breakpoint_watchpoint_probe_core_defines.svh -----
// Assertion macros shared by the probe core.
`ifndef BUS_BREAKPOINT_WATCHPOINT_PROBE_CORE_DEFINES_SVH
`define BUS_BREAKPOINT_WATCHPOINT_PROBE_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BBWP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("probe check failed");

// Antecedent implies consequent in the next cycle.
`define BBWP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("probe check failed");

`endif

// ----- hdl/bbwp_pkg.sv -----
package bbwp_pkg;

   localparam int FETCH_ENTRIES_DEF = 32;
   localparam int RANGE_ENTRIES_DEF = 16;
   localparam int PORT_ENTRIES_DEF  = 8;
   localparam int TIME_BITS_DEF     = 48;

   localparam logic [3:0] CMD_BUS        = 4'd0;
   localparam logic [3:0] CMD_ADD_EXEC   = 4'd1;
   localparam logic [3:0] CMD_DEL_EXEC   = 4'd2;
   localparam logic [3:0] CMD_CLR_EXEC   = 4'd3;
   localparam logic [3:0] CMD_ADD_WATCH  = 4'd4;
   localparam logic [3:0] CMD_DEL_WATCH  = 4'd5;
   localparam logic [3:0] CMD_CLR_WATCH  = 4'd6;
   localparam logic [3:0] CMD_ADD_IO     = 4'd7;
   localparam logic [3:0] CMD_DEL_IO     = 4'd8;
   localparam logic [3:0] CMD_CLR_IO     = 4'd9;
   localparam logic [3:0] CMD_ACK        = 4'd10;
   localparam logic [3:0] CMD_TGT_RESET  = 4'd11;

   localparam logic [2:0] HIT_NONE     = 3'd0;
   localparam logic [2:0] HIT_EXEC     = 3'd1;
   localparam logic [2:0] HIT_MEM_RD   = 3'd2;
   localparam logic [2:0] HIT_MEM_WR   = 3'd3;
   localparam logic [2:0] HIT_IO_RD    = 3'd4;
   localparam logic [2:0] HIT_IO_WR    = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_type;

   typedef struct packed {
      logic [15:0] base;
      logic [15:0] len;
      logic        rd;
      logic        wr;
   } range_entry_type;

   typedef struct packed {
      logic [15:0] value;
      logic [15:0] mask;
      logic        rd;
      logic        wr;
   } port_entry_type;

endpackage

// ----- hdl/bbwp_ctrl.sv -----
module bbwp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbwp_pkg::ctl_type ctl
);

   bbwp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbwp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbwp_pkg::ST_IDLE: begin
            if (req_valid) state_in = bbwp_pkg::ST_RUN;
         end
         bbwp_pkg::ST_RUN: begin
            state_in = bbwp_pkg::ST_DONE;
         end
         bbwp_pkg::ST_DONE: begin
            if (rsp_ready) state_in = bbwp_pkg::ST_IDLE;
         end
         default: state_in = bbwp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == bbwp_pkg::ST_IDLE);
      rsp_valid   = (state_ff == bbwp_pkg::ST_DONE);
      ctl.capture = req_ready && req_valid;
      ctl.execute = (state_ff == bbwp_pkg::ST_RUN);
   end

endmodule

// ----- hdl/bbwp_dp.sv -----
module bbwp_dp #(
   parameter int FETCH_ENTRIES = bbwp_pkg::FETCH_ENTRIES_DEF,
   parameter int RANGE_ENTRIES = bbwp_pkg::RANGE_ENTRIES_DEF,
   parameter int PORT_ENTRIES  = bbwp_pkg::PORT_ENTRIES_DEF,
   parameter int TIME_BITS     = bbwp_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bbwp_pkg::ctl_type ctl,
   input  logic [3:0]        req_command,
   input  logic [15:0]       req_address,
   input  logic [7:0]        req_bus_data,
   input  logic              req_m1_strobe,
   input  logic              req_mreq_strobe,
   input  logic              req_iorq_strobe,
   input  logic              req_rd_strobe,
   input  logic              req_wr_strobe,
   input  logic [15:0]       req_range_length,
   input  logic [15:0]       req_io_mask,
   input  logic              req_trigger_on_read,
   input  logic              req_trigger_on_write,
   output logic              rsp_status,
   output logic [2:0]        rsp_hit_kind,
   output logic [15:0]       rsp_hit_address,
   output logic [7:0]        rsp_hit_data,
   output logic [47:0]       rsp_hit_timestamp,
   output logic              rsp_armed,
   output logic              rsp_active
);

   localparam int FCW = $clog2(FETCH_ENTRIES + 1);
   localparam int RCW = $clog2(RANGE_ENTRIES + 1);
   localparam int PCW = $clog2(PORT_ENTRIES + 1);
   localparam int FIW = (FETCH_ENTRIES > 1) ? $clog2(FETCH_ENTRIES) : 1;
   localparam int RIW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
   localparam int PIW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;

   // Captured request.
   logic [3:0]  cmd_ff;
   logic [15:0] addr_ff, len_ff, mask_ff;
   logic [7:0]  data_ff;
   logic        m1_ff, mreq_ff, iorq_ff, rd_ff, wr_ff, onr_ff, onw_ff;

   // Tables and state.
   logic [15:0]               ft_ff [FETCH_ENTRIES];
   bbwp_pkg::range_entry_type rt_ff [RANGE_ENTRIES];
   bbwp_pkg::port_entry_type  pt_ff [PORT_ENTRIES];
   logic [FCW-1:0]  fc_ff, fc_in, fc_m1;
   logic [RCW-1:0]  rc_ff, rc_in, rc_m1;
   logic [PCW-1:0]  pc_ff, pc_in, pc_m1;
   logic [4:0]      prev_ff, prev_in;
   logic [2:0]      kind_ff, kind_in;
   logic [15:0]     laddr_ff, laddr_in;
   logic [7:0]      ldata_ff, ldata_in;
   logic [TIME_BITS-1:0] ltime_ff, ltime_in, cnt_ff, cnt_in;
   logic            status_ff, status_in;

   // Table write ports.
   logic                      fwe, rwe, pwe;
   logic [FIW-1:0]            fwi;
   logic [RIW-1:0]            rwi;
   logic [PIW-1:0]            pwi;
   logic [15:0]               fwd;
   bbwp_pkg::range_entry_type rwd;
   bbwp_pkg::port_entry_type  pwd;

   // Comparator results.
   logic [FETCH_ENTRIES-1:0] f_hit;
   logic [RANGE_ENTRIES-1:0] r_base, r_dup, r_fire;
   logic [PORT_ENTRIES-1:0]  p_dup, p_fire;
   logic [FIW-1:0] f_idx;
   logic [RIW-1:0] rb_idx, rd_idx, rf_idx;
   logic [PIW-1:0] pd_idx, pf_idx;
   logic [15:0]    len1;
   logic [4:0]     now, edges;
   logic           empty;
   logic [63:0]    ts_wide;

   assign len1  = (len_ff == 16'd0) ? 16'd1 : len_ff;
   assign fc_m1 = fc_ff - 1'b1;
   assign rc_m1 = rc_ff - 1'b1;
   assign pc_m1 = pc_ff - 1'b1;
   assign empty = (fc_ff == '0) && (rc_ff == '0) && (pc_ff == '0);

   assign now = {iorq_ff & wr_ff & ~m1_ff, iorq_ff & rd_ff & ~m1_ff,
                 mreq_ff & wr_ff, mreq_ff & rd_ff, m1_ff & mreq_ff & rd_ff};
   assign edges = now & ~prev_ff;

   always_comb begin
      logic [16:0] last;
      for (int i = 0; i < FETCH_ENTRIES; i++) begin
         f_hit[i] = (FCW'(i) < fc_ff) && (ft_ff[i] == addr_ff);
      end
      for (int i = 0; i < RANGE_ENTRIES; i++) begin
         last = {1'b0, rt_ff[i].base} + {1'b0, rt_ff[i].len} - 17'd1;
         r_base[i] = (RCW'(i) < rc_ff) && (rt_ff[i].base == addr_ff);
         r_dup[i]  = r_base[i] && (rt_ff[i].len == len1);
         r_fire[i] = (RCW'(i) < rc_ff) && (addr_ff >= rt_ff[i].base)
                     && ({1'b0, addr_ff} <= last)
                     && ((edges[1] && rt_ff[i].rd) || (edges[2] && rt_ff[i].wr));
      end
      for (int i = 0; i < PORT_ENTRIES; i++) begin
         p_dup[i]  = (PCW'(i) < pc_ff) && (pt_ff[i].value == addr_ff)
                     && (pt_ff[i].mask == mask_ff);
         p_fire[i] = (PCW'(i) < pc_ff)
                     && ((addr_ff & pt_ff[i].mask) == (pt_ff[i].value & pt_ff[i].mask))
                     && ((edges[3] && pt_ff[i].rd) || (edges[4] && pt_ff[i].wr));
      end
   end

   // First-match index of each comparator row.
   always_comb begin
      f_idx  = '0;
      rb_idx = '0;
      rd_idx = '0;
      rf_idx = '0;
      pd_idx = '0;
      pf_idx = '0;
      for (int i = FETCH_ENTRIES - 1; i >= 0; i--) begin
         if (f_hit[i]) f_idx = FIW'(i);
      end
      for (int i = RANGE_ENTRIES - 1; i >= 0; i--) begin
         if (r_base[i]) rb_idx = RIW'(i);
         if (r_dup[i])  rd_idx = RIW'(i);
         if (r_fire[i]) rf_idx = RIW'(i);
      end
      for (int i = PORT_ENTRIES - 1; i >= 0; i--) begin
         if (p_dup[i])  pd_idx = PIW'(i);
         if (p_fire[i]) pf_idx = PIW'(i);
      end
   end

   always_comb begin
      fc_in     = fc_ff;
      rc_in     = rc_ff;
      pc_in     = pc_ff;
      prev_in   = prev_ff;
      kind_in   = kind_ff;
      laddr_in  = laddr_ff;
      ldata_in  = ldata_ff;
      ltime_in  = ltime_ff;
      cnt_in    = cnt_ff;
      status_in = 1'b0;
      fwe = 1'b0;
      fwi = fc_ff[FIW-1:0];
      fwd = addr_ff;
      rwe = 1'b0;
      rwi = rc_ff[RIW-1:0];
      rwd = '{base: addr_ff, len: len1, rd: onr_ff, wr: onw_ff};
      pwe = 1'b0;
      pwi = pc_ff[PIW-1:0];
      pwd = '{value: addr_ff, mask: mask_ff, rd: onr_ff, wr: onw_ff};
      unique case (cmd_ff)
         bbwp_pkg::CMD_BUS: begin
            if (!(empty && kind_ff == bbwp_pkg::HIT_NONE)) begin
               cnt_in  = cnt_ff + 1'b1;
               prev_in = now;
               if (kind_ff == bbwp_pkg::HIT_NONE && !empty) begin
                  priority if (edges[0] && |f_hit) begin
                     kind_in = bbwp_pkg::HIT_EXEC;
                  end else if (|r_fire) begin
                     kind_in = (edges[1] && rt_ff[rf_idx].rd) ? bbwp_pkg::HIT_MEM_RD
                                                              : bbwp_pkg::HIT_MEM_WR;
                  end else if (|p_fire) begin
                     kind_in = (edges[3] && pt_ff[pf_idx].rd) ? bbwp_pkg::HIT_IO_RD
                                                              : bbwp_pkg::HIT_IO_WR;
                  end else begin
                     kind_in = bbwp_pkg::HIT_NONE;
                  end
                  if (kind_in != bbwp_pkg::HIT_NONE) begin
                     laddr_in = addr_ff;
                     ldata_in = data_ff;
                     ltime_in = cnt_in;
                  end
               end
            end
         end
         bbwp_pkg::CMD_ADD_EXEC: begin
            if (|f_hit || fc_ff >= FCW'(FETCH_ENTRIES)) begin
               status_in = 1'b1;
            end else begin
               fwe   = 1'b1;
               fc_in = fc_ff + 1'b1;
            end
         end
         bbwp_pkg::CMD_DEL_EXEC: begin
            if (|f_hit) begin
               fwe   = 1'b1;
               fwi   = f_idx;
               fwd   = ft_ff[fc_m1[FIW-1:0]];
               fc_in = fc_m1;
            end else begin
               status_in = 1'b1;
            end
         end
         bbwp_pkg::CMD_CLR_EXEC: fc_in = '0;
         bbwp_pkg::CMD_ADD_WATCH: begin
            if (!onr_ff && !onw_ff) begin
               status_in = 1'b1;
            end else if (|r_dup) begin
               // Same base and length: fold the new directions into the entry.
               rwe = 1'b1;
               rwi = rd_idx;
               rwd.rd = rt_ff[rd_idx].rd | onr_ff;
               rwd.wr = rt_ff[rd_idx].wr | onw_ff;
            end else if (rc_ff >= RCW'(RANGE_ENTRIES)) begin
               status_in = 1'b1;
            end else begin
               rwe   = 1'b1;
               rc_in = rc_ff + 1'b1;
            end
         end
         bbwp_pkg::CMD_DEL_WATCH: begin
            if (|r_base) begin
               rwe   = 1'b1;
               rwi   = rb_idx;
               rwd   = rt_ff[rc_m1[RIW-1:0]];
               rc_in = rc_m1;
            end else begin
               status_in = 1'b1;
            end
         end
         bbwp_pkg::CMD_CLR_WATCH: rc_in = '0;
         bbwp_pkg::CMD_ADD_IO: begin
            if (|p_dup || pc_ff >= PCW'(PORT_ENTRIES) || (!onr_ff && !onw_ff)) begin
               status_in = 1'b1;
            end else begin
               pwe   = 1'b1;
               pc_in = pc_ff + 1'b1;
            end
         end
         bbwp_pkg::CMD_DEL_IO: begin
            if (|p_dup) begin
               pwe   = 1'b1;
               pwi   = pd_idx;
               pwd   = pt_ff[pc_m1[PIW-1:0]];
               pc_in = pc_m1;
            end else begin
               status_in = 1'b1;
            end
         end
         bbwp_pkg::CMD_CLR_IO: pc_in = '0;
         bbwp_pkg::CMD_ACK: begin
            kind_in  = bbwp_pkg::HIT_NONE;
            laddr_in = '0;
            ldata_in = '0;
            ltime_in = '0;
         end
         bbwp_pkg::CMD_TGT_RESET: begin
            kind_in  = bbwp_pkg::HIT_NONE;
            laddr_in = '0;
            ldata_in = '0;
            ltime_in = '0;
            prev_in  = '0;
         end
         default: status_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
         data_ff <= req_bus_data;
         m1_ff   <= req_m1_strobe;
         mreq_ff <= req_mreq_strobe;
         iorq_ff <= req_iorq_strobe;
         rd_ff   <= req_rd_strobe;
         wr_ff   <= req_wr_strobe;
         len_ff  <= req_range_length;
         mask_ff <= req_io_mask;
         onr_ff  <= req_trigger_on_read;
         onw_ff  <= req_trigger_on_write;
      end
      if (ctl.execute) begin
         if (fwe) ft_ff[fwi] <= fwd;
         if (rwe) rt_ff[rwi] <= rwd;
         if (pwe) pt_ff[pwi] <= pwd;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff    <= '0;
         rc_ff    <= '0;
         pc_ff    <= '0;
         prev_ff  <= '0;
         kind_ff  <= bbwp_pkg::HIT_NONE;
         laddr_ff <= '0;
         ldata_ff <= '0;
         ltime_ff <= '0;
         cnt_ff   <= '0;
      end else if (ctl.execute) begin
         fc_ff    <= fc_in;
         rc_ff    <= rc_in;
         pc_ff    <= pc_in;
         prev_ff  <= prev_in;
         kind_ff  <= kind_in;
         laddr_ff <= laddr_in;
         ldata_ff <= ldata_in;
         ltime_ff <= ltime_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign ts_wide           = 64'(ltime_ff);
   assign rsp_status        = status_ff;
   assign rsp_hit_kind      = kind_ff;
   assign rsp_hit_address   = laddr_ff;
   assign rsp_hit_data      = ldata_ff;
   assign rsp_hit_timestamp = ts_wide[47:0];
   assign rsp_armed         = !empty;
   assign rsp_active        = !empty || (kind_ff != bbwp_pkg::HIT_NONE);

endmodule

// ----- hdl/bus_breakpoint_watchpoint_probe_core.sv -----
// Passive breakpoint and watchpoint probe for an 8-bit processor bus.
// The req_ channel carries one request per bus cycle or table command; the
// rsp_ channel returns exactly one response per request, with a status bit
// and the currently latched hit (kind, address, data, timestamp) plus the
// armed and active flags as they stand after the request took effect.
// Each request is captured into registers as it is accepted; in the execute
// state the parallel comparators and the table write ports act on it; the
// done state then presents the response. A new request is taken the cycle
// after the response is accepted, so no request is taken while one is open.
// All comparators are evaluated in parallel in the execute state.
// While rsp_ready is low the response holds and req_ready stays low.
// Reset empties the three tables, clears the hit latch, the previous-strobe
// history and the cycle counter. Table contents beyond each fill count are
// never read, so the tables need no clearing pass.
`include "bus_breakpoint_watchpoint_probe_core_defines.svh"

module bus_breakpoint_watchpoint_probe_core #(
   parameter int FETCH_ENTRIES = bbwp_pkg::FETCH_ENTRIES_DEF,
   parameter int RANGE_ENTRIES = bbwp_pkg::RANGE_ENTRIES_DEF,
   parameter int PORT_ENTRIES  = bbwp_pkg::PORT_ENTRIES_DEF,
   parameter int TIME_BITS     = bbwp_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_bus_data,
   input  logic        req_m1_strobe,
   input  logic        req_mreq_strobe,
   input  logic        req_iorq_strobe,
   input  logic        req_rd_strobe,
   input  logic        req_wr_strobe,
   input  logic [15:0] req_range_length,
   input  logic [15:0] req_io_mask,
   input  logic        req_trigger_on_read,
   input  logic        req_trigger_on_write,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [2:0]  rsp_hit_kind,
   output logic [15:0] rsp_hit_address,
   output logic [7:0]  rsp_hit_data,
   output logic [47:0] rsp_hit_timestamp,
   output logic        rsp_armed,
   output logic        rsp_active
);

   bbwp_pkg::ctl_type ctl;

   bbwp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   bbwp_dp #(
      .FETCH_ENTRIES (FETCH_ENTRIES),
      .RANGE_ENTRIES (RANGE_ENTRIES),
      .PORT_ENTRIES  (PORT_ENTRIES),
      .TIME_BITS     (TIME_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .req_command          (req_command),
      .req_address          (req_address),
      .req_bus_data         (req_bus_data),
      .req_m1_strobe        (req_m1_strobe),
      .req_mreq_strobe      (req_mreq_strobe),
      .req_iorq_strobe      (req_iorq_strobe),
      .req_rd_strobe        (req_rd_strobe),
      .req_wr_strobe        (req_wr_strobe),
      .req_range_length     (req_range_length),
      .req_io_mask          (req_io_mask),
      .req_trigger_on_read  (req_trigger_on_read),
      .req_trigger_on_write (req_trigger_on_write),
      .rsp_status           (rsp_status),
      .rsp_hit_kind         (rsp_hit_kind),
      .rsp_hit_address      (rsp_hit_address),
      .rsp_hit_data         (rsp_hit_data),
      .rsp_hit_timestamp    (rsp_hit_timestamp),
      .rsp_armed            (rsp_armed),
      .rsp_active           (rsp_active)
   );

   // One request in flight: input side closed while a response is shown.
   `BBWP_ASSERT_IMPL(a_one_in_flight, rsp_valid, !req_ready)
   // An accepted request is executed first and answered in the done state after it.
   `BBWP_ASSERT_NEXT(a_latency, req_valid && req_ready, !rsp_valid ##1 rsp_valid)
   // Armed tables always keep the probe active.
   `BBWP_ASSERT_IMPL(a_armed_active, rsp_armed, rsp_active)
   // With no hit latched, the hit address and timestamp read as zero.
   `BBWP_ASSERT_IMPL(a_idle_latch, rsp_valid && rsp_hit_kind == bbwp_pkg::HIT_NONE,
                     rsp_hit_address == 16'd0 && rsp_hit_timestamp == 48'd0)

endmodule

// ----- dv/bus_breakpoint_watchpoint_probe_core_test.sv -----
`timescale 1ns / 100ps

module bus_breakpoint_watchpoint_probe_core_test;

   localparam int FETCH_N = bbwp_pkg::FETCH_ENTRIES_DEF;
   localparam int RANGE_N = bbwp_pkg::RANGE_ENTRIES_DEF;
   localparam int PORT_N  = bbwp_pkg::PORT_ENTRIES_DEF;
   localparam logic [3:0] CMD_UNKNOWN_FIRST = 4'd12;
   localparam logic [3:0] CMD_UNKNOWN_LAST  = 4'd15;

   typedef struct {
      logic [3:0]  cmd;
      logic [15:0] addr;
      logic [7:0]  data;
      bit          m1, mreq, iorq, rd, wr;
      logic [15:0] len;
      logic [15:0] mask;
      bit          onr, onw;
   } probe_req_type;

   typedef struct {
      bit          status;
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [47:0] stamp;
      bit          armed;
      bit          active;
   } probe_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_command = bbwp_pkg::CMD_BUS;
   logic [15:0] req_address = '0;
   logic [7:0]  req_bus_data = '0;
   logic        req_m1_strobe = 1'b0;
   logic        req_mreq_strobe = 1'b0;
   logic        req_iorq_strobe = 1'b0;
   logic        req_rd_strobe = 1'b0;
   logic        req_wr_strobe = 1'b0;
   logic [15:0] req_range_length = '0;
   logic [15:0] req_io_mask = '0;
   logic        req_trigger_on_read = 1'b0;
   logic        req_trigger_on_write = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [2:0]  rsp_hit_kind;
   logic [15:0] rsp_hit_address;
   logic [7:0]  rsp_hit_data;
   logic [47:0] rsp_hit_timestamp;
   logic        rsp_armed;
   logic        rsp_active;

   bus_breakpoint_watchpoint_probe_core dut (.*);

   always #1 clock = ~clock;

   // Probe state as the predictor sees it.
   logic [15:0] fetch_addr [FETCH_N];
   int          fetch_cnt;
   logic [15:0] win_base [RANGE_N];
   logic [16:0] win_len [RANGE_N];
   bit          win_rd [RANGE_N], win_wr [RANGE_N];
   int          win_cnt;
   logic [15:0] port_val [PORT_N], port_msk [PORT_N];
   bit          port_rd [PORT_N], port_wr [PORT_N];
   int          port_cnt;
   logic [4:0]  prev_strobes;
   logic [2:0]  hit_kind_q;
   logic [15:0] hit_addr_q;
   logic [7:0]  hit_data_q;
   logic [47:0] hit_time_q;
   logic [47:0] tick_count;

   probe_rsp_type expected_hits[$];
   int            errors = 0;
   bit            idle_on = 1'b1;
   int            hold_off = 0;

   function automatic bit tables_empty();
      return fetch_cnt == 0 && win_cnt == 0 && port_cnt == 0;
   endfunction

   function automatic void latch_hit(logic [2:0] kind, logic [15:0] a, logic [7:0] d);
      hit_kind_q = kind;
      hit_addr_q = a;
      hit_data_q = d;
      hit_time_q = tick_count;
   endfunction

   function automatic void clear_hit();
      hit_kind_q = bbwp_pkg::HIT_NONE;
      hit_addr_q = '0;
      hit_data_q = '0;
      hit_time_q = '0;
   endfunction

   function automatic void probe_bus_cycle(probe_req_type r);
      logic [4:0] now;
      logic [4:0] rise;
      bit         done;
      done = 1'b0;
      if (tables_empty() && hit_kind_q == bbwp_pkg::HIT_NONE) return;
      tick_count = tick_count + 48'd1;
      now = {r.iorq & r.wr & ~r.m1, r.iorq & r.rd & ~r.m1, r.mreq & r.wr,
             r.mreq & r.rd, r.m1 & r.mreq & r.rd};
      rise = now & ~prev_strobes;
      prev_strobes = now;
      if (hit_kind_q != bbwp_pkg::HIT_NONE || tables_empty()) return;
      if (rise[0]) begin
         for (int i = 0; i < fetch_cnt && !done; i++) begin
            if (fetch_addr[i] == r.addr) begin
               latch_hit(bbwp_pkg::HIT_EXEC, r.addr, r.data);
               done = 1'b1;
            end
         end
      end
      if (!done && (rise[1] || rise[2])) begin
         for (int i = 0; i < win_cnt && !done; i++) begin
            if ({1'b0, r.addr} >= {1'b0, win_base[i]} &&
                {1'b0, r.addr} <= {1'b0, win_base[i]} + win_len[i] - 17'd1) begin
               if (rise[1] && win_rd[i]) begin
                  latch_hit(bbwp_pkg::HIT_MEM_RD, r.addr, r.data);
                  done = 1'b1;
               end else if (rise[2] && win_wr[i]) begin
                  latch_hit(bbwp_pkg::HIT_MEM_WR, r.addr, r.data);
                  done = 1'b1;
               end
            end
         end
      end
      if (!done && (rise[3] || rise[4])) begin
         for (int i = 0; i < port_cnt && !done; i++) begin
            if ((r.addr & port_msk[i]) == (port_val[i] & port_msk[i])) begin
               if (rise[3] && port_rd[i]) begin
                  latch_hit(bbwp_pkg::HIT_IO_RD, r.addr, r.data);
                  done = 1'b1;
               end else if (rise[4] && port_wr[i]) begin
                  latch_hit(bbwp_pkg::HIT_IO_WR, r.addr, r.data);
                  done = 1'b1;
               end
            end
         end
      end
   endfunction

   // Applies one request to the predicted state and returns the response.
   function automatic probe_rsp_type predict_probe(probe_req_type r);
      probe_rsp_type p;
      logic [16:0]   len;
      bit            rej;
      bit            found;
      rej = 1'b0;
      found = 1'b0;
      len = (r.len == 16'd0) ? 17'd1 : {1'b0, r.len};
      unique case (r.cmd)
         bbwp_pkg::CMD_BUS: probe_bus_cycle(r);
         bbwp_pkg::CMD_ADD_EXEC: begin
            for (int i = 0; i < fetch_cnt; i++) if (fetch_addr[i] == r.addr) found = 1'b1;
            if (found || fetch_cnt >= FETCH_N) rej = 1'b1;
            else begin
               fetch_addr[fetch_cnt] = r.addr;
               fetch_cnt++;
            end
         end
         bbwp_pkg::CMD_DEL_EXEC: begin
            for (int i = 0; i < fetch_cnt && !found; i++) begin
               if (fetch_addr[i] == r.addr) begin
                  fetch_cnt--;
                  fetch_addr[i] = fetch_addr[fetch_cnt];
                  found = 1'b1;
               end
            end
            rej = !found;
         end
         bbwp_pkg::CMD_CLR_EXEC: fetch_cnt = 0;
         bbwp_pkg::CMD_ADD_WATCH: begin
            if (!r.onr && !r.onw) rej = 1'b1;
            else begin
               for (int i = 0; i < win_cnt && !found; i++) begin
                  if (win_base[i] == r.addr && win_len[i] == len) begin
                     win_rd[i] |= r.onr;
                     win_wr[i] |= r.onw;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  if (win_cnt >= RANGE_N) rej = 1'b1;
                  else begin
                     win_base[win_cnt] = r.addr;
                     win_len[win_cnt] = len;
                     win_rd[win_cnt] = r.onr;
                     win_wr[win_cnt] = r.onw;
                     win_cnt++;
                  end
               end
            end
         end
         bbwp_pkg::CMD_DEL_WATCH: begin
            for (int i = 0; i < win_cnt && !found; i++) begin
               if (win_base[i] == r.addr) begin
                  win_cnt--;
                  win_base[i] = win_base[win_cnt];
                  win_len[i] = win_len[win_cnt];
                  win_rd[i] = win_rd[win_cnt];
                  win_wr[i] = win_wr[win_cnt];
                  found = 1'b1;
               end
            end
            rej = !found;
         end
         bbwp_pkg::CMD_CLR_WATCH: win_cnt = 0;
         bbwp_pkg::CMD_ADD_IO: begin
            for (int i = 0; i < port_cnt; i++)
               if (port_val[i] == r.addr && port_msk[i] == r.mask) found = 1'b1;
            if (found || port_cnt >= PORT_N || (!r.onr && !r.onw)) rej = 1'b1;
            else begin
               port_val[port_cnt] = r.addr;
               port_msk[port_cnt] = r.mask;
               port_rd[port_cnt] = r.onr;
               port_wr[port_cnt] = r.onw;
               port_cnt++;
            end
         end
         bbwp_pkg::CMD_DEL_IO: begin
            for (int i = 0; i < port_cnt && !found; i++) begin
               if (port_val[i] == r.addr && port_msk[i] == r.mask) begin
                  port_cnt--;
                  port_val[i] = port_val[port_cnt];
                  port_msk[i] = port_msk[port_cnt];
                  port_rd[i] = port_rd[port_cnt];
                  port_wr[i] = port_wr[port_cnt];
                  found = 1'b1;
               end
            end
            rej = !found;
         end
         bbwp_pkg::CMD_CLR_IO: port_cnt = 0;
         bbwp_pkg::CMD_ACK: clear_hit();
         bbwp_pkg::CMD_TGT_RESET: begin
            clear_hit();
            prev_strobes = '0;
         end
         default: rej = 1'b1;
      endcase
      p.status = rej;
      p.kind = hit_kind_q;
      p.addr = hit_addr_q;
      p.data = hit_data_q;
      p.stamp = hit_time_q;
      p.armed = !tables_empty();
      p.active = !tables_empty() || hit_kind_q != bbwp_pkg::HIT_NONE;
      return p;
   endfunction

   // Unused fields get random values so every input bit toggles.
   function automatic probe_req_type noise_req(logic [3:0] cmd);
      probe_req_type r;
      r.cmd = cmd;
      r.addr = 16'($urandom);
      r.data = 8'($urandom);
      {r.m1, r.mreq, r.iorq, r.rd, r.wr} = 5'($urandom);
      r.len = 16'($urandom);
      r.mask = 16'($urandom);
      {r.onr, r.onw} = 2'($urandom);
      return r;
   endfunction

   function automatic probe_req_type table_req(logic [3:0] cmd, logic [15:0] a,
                                               logic [15:0] len, logic [15:0] mask,
                                               bit onr, bit onw);
      probe_req_type r;
      r = noise_req(cmd);
      r.addr = a;
      r.len = len;
      r.mask = mask;
      r.onr = onr;
      r.onw = onw;
      return r;
   endfunction

   function automatic probe_req_type bus_req(logic [15:0] a, logic [7:0] d,
                                             logic [4:0] strobes);
      probe_req_type r;
      r = noise_req(bbwp_pkg::CMD_BUS);
      r.addr = a;
      r.data = d;
      {r.m1, r.mreq, r.iorq, r.rd, r.wr} = strobes;
      return r;
   endfunction

   task automatic send_request(probe_req_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.cmd;
      req_address <= r.addr;
      req_bus_data <= r.data;
      req_m1_strobe <= r.m1;
      req_mreq_strobe <= r.mreq;
      req_iorq_strobe <= r.iorq;
      req_rd_strobe <= r.rd;
      req_wr_strobe <= r.wr;
      req_range_length <= r.len;
      req_io_mask <= r.mask;
      req_trigger_on_read <= r.onr;
      req_trigger_on_write <= r.onw;
      do @(posedge clock); while (!req_ready);
      expected_hits.push_back(predict_probe(r));
   endtask

   task automatic wait_drained();
      while (expected_hits.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, plus an optional long hold-off.
   initial begin
      probe_rsp_type e;
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 6) : 0;
         if (hold_off > 0) begin
            stall = hold_off;
            hold_off = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_hits.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = expected_hits.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_hit_kind !== e.kind) begin
               $error("hit_kind expected %0d actual %0d", e.kind, rsp_hit_kind);
               errors++;
            end
            if (rsp_hit_address !== e.addr) begin
               $error("hit_address expected %h actual %h", e.addr, rsp_hit_address);
               errors++;
            end
            if (rsp_hit_data !== e.data) begin
               $error("hit_data expected %h actual %h", e.data, rsp_hit_data);
               errors++;
            end
            if (rsp_hit_timestamp !== e.stamp) begin
               $error("hit_timestamp expected %0d actual %0d", e.stamp, rsp_hit_timestamp);
               errors++;
            end
            if (rsp_armed !== e.armed) begin
               $error("armed expected %0d actual %0d", e.armed, rsp_armed);
               errors++;
            end
            if (rsp_active !== e.active) begin
               $error("active expected %0d actual %0d", e.active, rsp_active);
               errors++;
            end
         end
      end
   end

   // Strobe order is {m1, mreq, iorq, rd, wr}.
   task automatic test_directed();
      send_request(bus_req(16'hffff, 8'hff, 5'b11111));
      send_request(noise_req(CMD_UNKNOWN_LAST));
      send_request(noise_req(CMD_UNKNOWN_FIRST));
      send_request(table_req(bbwp_pkg::CMD_DEL_EXEC, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_ADD_EXEC, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_ADD_EXEC, 16'hffff, 16'd0, 16'd0, 1'b0, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_ADD_EXEC, 16'hffff, 16'd0, 16'd0, 1'b0, 1'b0));
      send_request(bus_req(16'h0000, 8'h00, 5'b00000));
      send_request(bus_req(16'hffff, 8'hff, 5'b11010));
      send_request(bus_req(16'h0000, 8'h00, 5'b00000));
      send_request(bus_req(16'h0000, 8'h5a, 5'b11010));
      send_request(noise_req(bbwp_pkg::CMD_ACK));
      // A zero length counts as one; a range ending past the top does not wrap.
      send_request(table_req(bbwp_pkg::CMD_ADD_WATCH, 16'hffff, 16'h0000, 16'd0, 1'b1, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_ADD_WATCH, 16'hfff0, 16'hffff, 16'd0, 1'b0, 1'b1));
      send_request(table_req(bbwp_pkg::CMD_ADD_WATCH, 16'h1000, 16'h0010, 16'd0, 1'b0, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_ADD_WATCH, 16'hfff0, 16'hffff, 16'd0, 1'b1, 1'b0));
      send_request(bus_req(16'hfff8, 8'ha5, 5'b01001));
      send_request(noise_req(bbwp_pkg::CMD_ACK));
      send_request(table_req(bbwp_pkg::CMD_ADD_IO, 16'h0012, 16'h0, 16'h00ff, 1'b1, 1'b1));
      send_request(table_req(bbwp_pkg::CMD_ADD_IO, 16'h0012, 16'h0, 16'h00ff, 1'b1, 1'b0));
      send_request(bus_req(16'h3412, 8'h11, 5'b10110));
      send_request(bus_req(16'h3412, 8'h22, 5'b00101));
      send_request(noise_req(bbwp_pkg::CMD_TGT_RESET));
      send_request(table_req(bbwp_pkg::CMD_DEL_IO, 16'h0012, 16'h0, 16'h00ff, 1'b0, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_DEL_WATCH, 16'hffff, 16'd0, 16'd0, 1'b0, 1'b0));
      send_request(noise_req(bbwp_pkg::CMD_CLR_EXEC));
      send_request(noise_req(bbwp_pkg::CMD_CLR_WATCH));
      send_request(noise_req(bbwp_pkg::CMD_CLR_IO));
   endtask

   task automatic test_table_full();
      for (int i = 0; i <= FETCH_N; i++)
         send_request(table_req(bbwp_pkg::CMD_ADD_EXEC, 16'(16'h4000 + i), 16'd0, 16'd0,
                                1'b0, 1'b0));
      for (int i = 0; i <= RANGE_N; i++)
         send_request(table_req(bbwp_pkg::CMD_ADD_WATCH, 16'(16'h8000 + 16 * i), 16'd8,
                                16'd0, 1'b1, 1'b1));
      for (int i = 0; i <= PORT_N; i++)
         send_request(table_req(bbwp_pkg::CMD_ADD_IO, 16'(16'h0040 + i), 16'd0, 16'hffff,
                                1'b1, 1'b1));
      send_request(table_req(bbwp_pkg::CMD_DEL_EXEC, 16'h4000, 16'd0, 16'd0, 1'b0, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_DEL_WATCH, 16'h8000, 16'd0, 16'd0, 1'b0, 1'b0));
      send_request(table_req(bbwp_pkg::CMD_DEL_IO, 16'h0040, 16'd0, 16'hffff, 1'b0, 1'b0));
      send_request(noise_req(bbwp_pkg::CMD_CLR_EXEC));
      send_request(noise_req(bbwp_pkg::CMD_CLR_WATCH));
      send_request(noise_req(bbwp_pkg::CMD_CLR_IO));
   endtask

   function automatic logic [15:0] pick_address();
      int k;
      k = $urandom_range(0, 9);
      if (k < 3 && fetch_cnt > 0) return fetch_addr[$urandom_range(0, fetch_cnt - 1)];
      if (k < 6 && win_cnt > 0) begin
         k = $urandom_range(0, win_cnt - 1);
         return win_base[k] + 16'($urandom_range(0, 3));
      end
      if (k < 8 && port_cnt > 0) begin
         k = $urandom_range(0, port_cnt - 1);
         return (port_val[k] & port_msk[k]) | (16'($urandom) & ~port_msk[k]);
      end
      return 16'($urandom);
   endfunction

   function automatic probe_req_type random_request();
      probe_req_type r;
      int k;
      k = $urandom_range(0, 99);
      r = noise_req(bbwp_pkg::CMD_BUS);
      if (k < 55) r.addr = pick_address();
      else if (k < 62) begin
         r.cmd = bbwp_pkg::CMD_ADD_EXEC;
         if ($urandom_range(0, 1)) r.addr = 16'($urandom_range(0, 63));
      end else if (k < 65) begin
         r.cmd = bbwp_pkg::CMD_DEL_EXEC;
         r.addr = pick_address();
      end else if (k < 66) r.cmd = bbwp_pkg::CMD_CLR_EXEC;
      else if (k < 73) begin
         r.cmd = bbwp_pkg::CMD_ADD_WATCH;
         if ($urandom_range(0, 3) != 0) r.len = 16'($urandom_range(0, 64));
      end else if (k < 75) begin
         r.cmd = bbwp_pkg::CMD_DEL_WATCH;
         if (win_cnt > 0 && $urandom_range(0, 1)) r.addr = win_base[$urandom_range(0, win_cnt - 1)];
      end else if (k < 76) r.cmd = bbwp_pkg::CMD_CLR_WATCH;
      else if (k < 82) begin
         r.cmd = bbwp_pkg::CMD_ADD_IO;
         if ($urandom_range(0, 1)) r.mask = 16'h00ff;
      end else if (k < 84) begin
         r.cmd = bbwp_pkg::CMD_DEL_IO;
         if (port_cnt > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, port_cnt - 1);
            r.addr = port_val[k];
            r.mask = port_msk[k];
         end
      end else if (k < 85) r.cmd = bbwp_pkg::CMD_CLR_IO;
      else if (k < 96) r.cmd = bbwp_pkg::CMD_ACK;
      else if (k < 98) r.cmd = bbwp_pkg::CMD_TGT_RESET;
      else r.cmd = 4'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
      return r;
   endfunction

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
         send_request(random_request());
      end
      idle_on = 1'b1;
   endtask

   // The response side stalls long enough that the request side backs up.
   task automatic test_backpressure();
      hold_off = 60;
      test_random(30);
   endtask

   task automatic test_sender_pause();
      wait_drained();
      test_random(20);
   endtask

   initial begin
      fetch_cnt = 0;
      win_cnt = 0;
      port_cnt = 0;
      prev_strobes = '0;
      tick_count = '0;
      clear_hit();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_backpressure();
      test_sender_pause();
      test_random(950);
      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
